FILE: rtl/cmbs_pkg.sv
// shared types, constants and gap arithmetic for the comb sort record block
`default_nettype none

package cmbs_pkg;

   localparam int KEY_W     = 27;
   localparam int TAG_W     = 16;
   localparam int DEPTH_DEF = 64;
   localparam int DEPTH_MAX = 64;

   // gap register width at the largest depth
   localparam int GAP_W = $clog2(DEPTH_MAX + 1);

   // g*10/13 as g*50420 >> 16, exact for every g up to the largest depth
   localparam int GAP_RECIP = 50420;
   localparam int GAP_SHIFT = 16;
   localparam int PROD_W    = GAP_W + GAP_SHIFT;

   localparam logic [GAP_W-1:0] GAP_ONE    = GAP_W'(1);
   localparam logic [GAP_W-1:0] GAP_NINE   = GAP_W'(9);
   localparam logic [GAP_W-1:0] GAP_TEN    = GAP_W'(10);
   localparam logic [GAP_W-1:0] GAP_ELEVEN = GAP_W'(11);

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } rec_type;

   typedef struct packed {
      logic valid;
      logic last;
   } rsp_ctl_type;

   function automatic logic [GAP_W-1:0] next_gap(input logic [GAP_W-1:0] g);
      logic [PROD_W-1:0] prod;
      logic [GAP_W-1:0]  q;
      prod = PROD_W'(g) * PROD_W'(GAP_RECIP);
      q    = prod[GAP_SHIFT +: GAP_W];
      if (q == GAP_NINE || q == GAP_TEN) begin
         q = GAP_ELEVEN;
      end
      if (q == '0) begin
         q = GAP_ONE;
      end
      return q;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/cmbs_mem.sv
// record store: one write port, two registered read ports
`default_nettype none

module cmbs_mem
   import cmbs_pkg::*;
#(
   parameter int DEPTH  = DEPTH_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire rec_type           wdata,
   input  wire logic              re,
   input  wire logic [ADDR_W-1:0] raddr_a,
   input  wire logic [ADDR_W-1:0] raddr_b,
   output rec_type                rdata_a,
   output rec_type                rdata_b
);

   rec_type store [DEPTH];
   rec_type rdata_a_ff;
   rec_type rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_a_ff <= store[raddr_a];
         rdata_b_ff <= store[raddr_b];
      end
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

`default_nettype wire

FILE: rtl/cmbs_ctrl.sv
// load, comb sort and read-out sequencer with the shared key comparator
`default_nettype none

module cmbs_ctrl
   import cmbs_pkg::*;
#(
   parameter int DEPTH  = DEPTH_DEF,
   parameter int ADDR_W = $clog2(DEPTH),
   parameter int CNT_W  = $clog2(DEPTH + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [KEY_W-1:0]  req_key,
   input  wire logic [TAG_W-1:0]  req_tag,
   input  wire logic              req_last,
   output logic                   busy,
   output logic                   mem_we,
   output logic [ADDR_W-1:0]      mem_waddr,
   output rec_type                mem_wdata,
   output logic                   mem_re,
   output logic [ADDR_W-1:0]      mem_raddr_a,
   output logic [ADDR_W-1:0]      mem_raddr_b,
   input  wire rec_type           mem_rdata_a,
   input  wire rec_type           mem_rdata_b,
   output rsp_ctl_type            rsp_ctl
);

   typedef enum logic [2:0] {
      S_LOAD,
      S_GAP,
      S_READ,
      S_CMP,
      S_WRB,
      S_OUT
   } state_type;

   state_type         state_ff,  state_in;
   logic [CNT_W-1:0]  count_ff,  count_in;
   logic [CNT_W-1:0]  gap_ff,    gap_in;
   logic [ADDR_W-1:0] idx_ff,    idx_in;
   logic              swap_ff,   swap_in;
   rsp_ctl_type       rsp_ff,    rsp_in;

   logic [CNT_W-1:0]  gap_new;
   logic [CNT_W-1:0]  idx_ext;
   logic [CNT_W-1:0]  idx_next;
   logic [CNT_W-1:0]  idx_b;
   logic [CNT_W:0]    pair_end;
   logic              more_pairs;
   logic              key_gt;
   logic              swap_now;
   logic              pass_clean;

   assign gap_new    = CNT_W'(next_gap(GAP_W'(gap_ff)));
   assign idx_ext    = CNT_W'(idx_ff);
   assign idx_next   = idx_ext + CNT_W'(1);
   assign idx_b      = idx_ext + gap_ff;
   assign pair_end   = (CNT_W+1)'(idx_next) + (CNT_W+1)'(gap_ff);
   assign more_pairs = pair_end < (CNT_W+1)'(count_ff);
   // the one comparator, shared by every pair of every pass
   assign key_gt     = mem_rdata_a.key > mem_rdata_b.key;
   assign swap_now   = swap_ff | (state_ff == S_CMP && key_gt);
   assign pass_clean = (gap_ff == CNT_W'(1)) && !swap_now;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      gap_in      = gap_ff;
      idx_in      = idx_ff;
      swap_in     = swap_ff;
      rsp_in      = '0;
      mem_we      = 1'b0;
      mem_waddr   = idx_ff;
      mem_wdata   = mem_rdata_b;
      mem_re      = 1'b0;
      mem_raddr_a = idx_ff;
      mem_raddr_b = idx_b[ADDR_W-1:0];

      unique case (state_ff)
         S_LOAD: begin
            if (start) begin
               if (count_ff < CNT_W'(DEPTH)) begin
                  mem_we    = 1'b1;
                  mem_waddr = count_ff[ADDR_W-1:0];
                  mem_wdata = '{key: req_key, tag: req_tag};
                  count_in  = count_ff + CNT_W'(1);
               end
               if (req_last) begin
                  gap_in   = count_in;
                  state_in = S_GAP;
               end
            end
         end
         S_GAP: begin
            gap_in  = gap_new;
            idx_in  = '0;
            swap_in = 1'b0;
            if (gap_new < count_ff) begin
               state_in = S_READ;
            end else if (gap_new == CNT_W'(1)) begin
               state_in = S_OUT;
            end
         end
         S_READ: begin
            mem_re   = 1'b1;
            state_in = S_CMP;
         end
         S_CMP, S_WRB: begin
            swap_in = swap_now;
            if (state_ff == S_CMP && key_gt) begin
               // low slot takes the high record now, high slot next cycle
               mem_we    = 1'b1;
               mem_waddr = idx_ff;
               mem_wdata = mem_rdata_b;
               state_in  = S_WRB;
            end else begin
               if (state_ff == S_WRB) begin
                  mem_we    = 1'b1;
                  mem_waddr = idx_b[ADDR_W-1:0];
                  mem_wdata = mem_rdata_a;
               end
               if (more_pairs) begin
                  idx_in   = idx_next[ADDR_W-1:0];
                  state_in = S_READ;
               end else if (pass_clean) begin
                  idx_in   = '0;
                  state_in = S_OUT;
               end else begin
                  state_in = S_GAP;
               end
            end
         end
         S_OUT: begin
            mem_re       = 1'b1;
            rsp_in.valid = 1'b1;
            rsp_in.last  = idx_next == count_ff;
            idx_in       = idx_next[ADDR_W-1:0];
            if (idx_next == count_ff) begin
               count_in = '0;
               gap_in   = '0;
               swap_in  = 1'b0;
               idx_in   = '0;
               state_in = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         count_ff <= '0;
         gap_ff   <= '0;
         idx_ff   <= '0;
         swap_ff  <= 1'b0;
         rsp_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         gap_ff   <= gap_in;
         idx_ff   <= idx_in;
         swap_ff  <= swap_in;
         rsp_ff   <= rsp_in;
      end
   end

   assign busy    = state_ff != S_LOAD;
   assign rsp_ctl = rsp_ff;

endmodule

`default_nettype wire

FILE: rtl/comb_sort_records.sv
// top level of the comb sort record block
//
// records (key, tag, last) are loaded one per cycle: a request is taken
// at a rising edge with start high and busy low. records past DEPTH are
// dropped, but a dropped record that carries last still closes the batch.
// a request with last high raises busy; the stored batch is then sorted
// ascending by key with comb sort (gap shrinks by 10/13, 9 and 10 go to
// 11, floor of 1) until a gap-1 pass makes no swap.
// sorting runs on one comparator over a two-read, one-write record store:
// each compared pair is read (S_READ) and compared (S_CMP), a swap adds
// a second write in S_WRB, and each pass first sets its gap in S_GAP.
// the sorted records then leave one per cycle on rsp_valid once the
// sort ends; rsp_end_of_batch marks the final one. busy
// falls in the cycle the final record is shown, so the next batch may
// start loading right away. results cannot be held off by the receiver.
// reset returns the block to loading with an empty batch; the store
// contents are not cleared and are never read before being written.
`default_nettype none

module comb_sort_records
   import cmbs_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire logic [KEY_W-1:0] req_key,
   input  wire logic [TAG_W-1:0] req_tag,
   input  wire logic             req_last,
   output logic                  rsp_valid,
   output logic [KEY_W-1:0]      rsp_sorted_key,
   output logic [TAG_W-1:0]      rsp_sorted_tag,
   output logic                  rsp_end_of_batch
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   rec_type           mem_wdata;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_raddr_a;
   logic [ADDR_W-1:0] mem_raddr_b;
   rec_type           mem_rdata_a;
   rec_type           mem_rdata_b;
   rsp_ctl_type       rsp_ctl;

   cmbs_ctrl #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W),
      .CNT_W  (CNT_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_key     (req_key),
      .req_tag     (req_tag),
      .req_last    (req_last),
      .busy        (busy),
      .mem_we      (mem_we),
      .mem_waddr   (mem_waddr),
      .mem_wdata   (mem_wdata),
      .mem_re      (mem_re),
      .mem_raddr_a (mem_raddr_a),
      .mem_raddr_b (mem_raddr_b),
      .mem_rdata_a (mem_rdata_a),
      .mem_rdata_b (mem_rdata_b),
      .rsp_ctl     (rsp_ctl)
   );

   cmbs_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .we      (mem_we),
      .waddr   (mem_waddr),
      .wdata   (mem_wdata),
      .re      (mem_re),
      .raddr_a (mem_raddr_a),
      .raddr_b (mem_raddr_b),
      .rdata_a (mem_rdata_a),
      .rdata_b (mem_rdata_b)
   );

   // read port a feeds the result registers directly during read-out
   assign rsp_valid        = rsp_ctl.valid;
   assign rsp_end_of_batch = rsp_ctl.last;
   assign rsp_sorted_key   = mem_rdata_a.key;
   assign rsp_sorted_tag   = mem_rdata_a.tag;

   a_last_starts_sort: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_last |=> busy)
      else $error("closing request did not start a sort");

   a_end_has_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_end_of_batch |-> rsp_valid)
      else $error("end of batch without a result");

   a_stream_unbroken: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_end_of_batch |=> rsp_valid)
      else $error("gap in sorted result stream");

   a_no_result_while_loading: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_end_of_batch |-> busy)
      else $error("result shown while loading");

endmodule

`default_nettype wire
